// ===== rtl/core/aacs_pkg.sv =====
package aacs_pkg;

  // Field widths
  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned RADIUS_BITS = 10;
  localparam int unsigned STROKE_BITS = 10;
  localparam int unsigned ALPHA_BITS  = 8;
  localparam int unsigned COV_BITS    = 9;    // coverage 0..256

  // Datapath widths, all but FRAC_W derived from the coordinate width
  localparam int unsigned DIFF_W = COORD_BITS + 1;        // coordinate difference
  localparam int unsigned PROD_W = 2 * DIFF_W;            // signed product / dot / cross
  localparam int unsigned SQ_W   = 2 * COORD_BITS + 1;    // sum of squares, |cross|
  localparam int unsigned NUM_W  = 2 * SQ_W;              // cross squared
  localparam int unsigned FRAC_W = 16;                    // 8 fraction bits, squared
  localparam int unsigned QUOT_W = 2 * COORD_BITS + 17;   // dist^2 in Q.16
  localparam int unsigned ROOT_W = (QUOT_W + 1) / 2;      // dist in Q.8
  localparam int unsigned RAD_W  = ROOT_W * 2;            // padded radicand

  localparam int unsigned CV_A = (ROOT_W > RADIUS_BITS + 8) ? ROOT_W : RADIUS_BITS + 8;
  localparam int unsigned CV_B = (CV_A > STROKE_BITS + 4) ? CV_A : STROKE_BITS + 4;
  localparam int unsigned CV_W = CV_B + 2;

  localparam int unsigned CFG_DA = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int unsigned CFG_DW = (CFG_DA > STROKE_BITS) ? CFG_DA : STROKE_BITS;
  localparam int unsigned CFG_IW = 3;

  localparam int unsigned OBUF_DEPTH = 2;
  localparam int unsigned OBUF_CW    = $clog2(OBUF_DEPTH + 1);

  // Half and whole pixel in 1/256 units
  localparam logic signed [CV_W-1:0] HALF_PX = CV_W'(128);
  localparam logic signed [CV_W-1:0] ONE_PX  = CV_W'(256);

  typedef enum logic [1:0] {
    SHAPE_DISC = 2'd0,
    SHAPE_RING = 2'd1,
    SHAPE_SEG  = 2'd2
  } shape_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_SHAPE_MODE    = 3'd0,
    REG_POINT_A_X     = 3'd1,
    REG_POINT_A_Y     = 3'd2,
    REG_POINT_B_X     = 3'd3,
    REG_POINT_B_Y     = 3'd4,
    REG_CIRCLE_RADIUS = 3'd5,
    REG_STROKE_WIDTH  = 3'd6,
    REG_BASE_ALPHA    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]                    shape_mode;
    logic signed [COORD_BITS-1:0]  point_a_x;
    logic signed [COORD_BITS-1:0]  point_a_y;
    logic signed [COORD_BITS-1:0]  point_b_x;
    logic signed [COORD_BITS-1:0]  point_b_y;
    logic [RADIUS_BITS-1:0]        circle_radius;
    logic [STROKE_BITS-1:0]        stroke_width;
    logic [ALPHA_BITS-1:0]         base_alpha;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    shape_mode:    2'd0,
    point_a_x:     '0,
    point_a_y:     '0,
    point_b_x:     '0,
    point_b_y:     '0,
    circle_radius: '0,
    stroke_width:  STROKE_BITS'(16),
    base_alpha:    ALPHA_BITS'(255)
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic [ALPHA_BITS-1:0]        out_alpha;
  } pix_out_t;

  // Geometry front end to divider
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [SQ_W-1:0]  den;
    pix_in_t          pix;
  } geo_t;

  function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

endpackage

// ===== rtl/core/aacs_geom.sv =====
module aacs_geom import aacs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  pix_in_t pix_i,
  input  cfg_t    cfg_i,
  output logic    valid_o,
  output geo_t    geo_o
);

  // Stage 1: differences
  logic                     s1_vld_q;
  pix_in_t                  s1_pix_q;
  logic signed [DIFF_W-1:0] s1_fx_q, s1_fy_q, s1_gx_q, s1_gy_q, s1_dx_q, s1_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en_i) s1_vld_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pix_q <= pix_i;
      s1_fx_q  <= sx(pix_i.pixel_x) - sx(cfg_i.point_a_x);
      s1_fy_q  <= sx(pix_i.pixel_y) - sx(cfg_i.point_a_y);
      s1_gx_q  <= sx(pix_i.pixel_x) - sx(cfg_i.point_b_x);
      s1_gy_q  <= sx(pix_i.pixel_y) - sx(cfg_i.point_b_y);
      s1_dx_q  <= sx(cfg_i.point_b_x) - sx(cfg_i.point_a_x);
      s1_dy_q  <= sx(cfg_i.point_b_y) - sx(cfg_i.point_a_y);
    end
  end

  // Stage 2: squares, dot and cross products
  logic signed [PROD_W-1:0] fxx, fyy, gxx, gyy, dxx, dyy;
  logic signed [PROD_W-1:0] sum_a, sum_b, sum_l, dot_d, crs_d;

  always_comb begin
    fxx   = s1_fx_q * s1_fx_q;
    fyy   = s1_fy_q * s1_fy_q;
    gxx   = s1_gx_q * s1_gx_q;
    gyy   = s1_gy_q * s1_gy_q;
    dxx   = s1_dx_q * s1_dx_q;
    dyy   = s1_dy_q * s1_dy_q;
    sum_a = fxx + fyy;
    sum_b = gxx + gyy;
    sum_l = dxx + dyy;
    dot_d = PROD_W'(s1_fx_q * s1_dx_q) + PROD_W'(s1_fy_q * s1_dy_q);
    crs_d = PROD_W'(s1_fx_q * s1_dy_q) - PROD_W'(s1_fy_q * s1_dx_q);
  end

  logic                     s2_vld_q;
  pix_in_t                  s2_pix_q;
  logic [SQ_W-1:0]          s2_d2a_q, s2_d2b_q, s2_len2_q;
  logic signed [PROD_W-1:0] s2_dot_q, s2_crs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (en_i) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_pix_q  <= s1_pix_q;
      s2_d2a_q  <= sum_a[SQ_W-1:0];
      s2_d2b_q  <= sum_b[SQ_W-1:0];
      s2_len2_q <= sum_l[SQ_W-1:0];
      s2_dot_q  <= dot_d;
      s2_crs_q  <= crs_d;
    end
  end

  // Stage 3: pick the nearest feature (end point or line body)
  logic                     line_d;
  logic [SQ_W-1:0]          d2_d;
  logic signed [PROD_W-1:0] crs_abs;

  always_comb begin
    line_d  = 1'b0;
    d2_d    = s2_d2a_q;
    crs_abs = (s2_crs_q < 0) ? -s2_crs_q : s2_crs_q;
    if (cfg_i.shape_mode == SHAPE_SEG && s2_len2_q != '0 && s2_dot_q > 0) begin
      if (s2_dot_q >= $signed({1'b0, s2_len2_q})) begin
        d2_d = s2_d2b_q;
      end else begin
        line_d = 1'b1;
      end
    end
  end

  logic            s3_vld_q, s3_line_q;
  pix_in_t         s3_pix_q;
  logic [SQ_W-1:0] s3_d2_q, s3_cr_q, s3_len2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (en_i) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_pix_q  <= s2_pix_q;
      s3_line_q <= line_d;
      s3_d2_q   <= d2_d;
      s3_cr_q   <= crs_abs[SQ_W-1:0];
      s3_len2_q <= s2_len2_q;
    end
  end

  // Stage 4: numerator and denominator of dist^2
  logic [NUM_W-1:0] cr2;
  logic             s4_vld_q;
  geo_t             s4_geo_q;

  assign cr2 = s3_cr_q * s3_cr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (en_i) s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_geo_q.pix <= s3_pix_q;
      s4_geo_q.num <= s3_line_q ? cr2 : NUM_W'(s3_d2_q);
      s4_geo_q.den <= s3_line_q ? s3_len2_q : SQ_W'(1);
    end
  end

  assign valid_o = s4_vld_q;
  assign geo_o   = s4_geo_q;

endmodule

// ===== rtl/core/aacs_div.sv =====
module aacs_div import aacs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  geo_t              geo_i,
  output logic              valid_o,
  output logic [QUOT_W-1:0] quot_o,
  output pix_in_t           pix_o
);

  // Restoring divider, one quotient bit per stage: floor(num * 2^16 / den)
  logic [NUM_W+FRAC_W-1:0] dvd;
  assign dvd = {geo_i.num, FRAC_W'(0)};

  logic              vld_q [QUOT_W];
  logic [SQ_W-1:0]   rem_q [QUOT_W];
  logic [SQ_W-1:0]   den_q [QUOT_W];
  logic [QUOT_W-1:0] wrd_q [QUOT_W];
  pix_in_t           pix_q [QUOT_W];

  for (genvar i = 0; i < QUOT_W; i++) begin : g_step
    logic              v_in;
    logic [SQ_W-1:0]   r_in, d_in;
    logic [QUOT_W-1:0] w_in;
    pix_in_t           p_in;
    logic [SQ_W:0]     trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = dvd[NUM_W+FRAC_W-1:QUOT_W];
      assign w_in = dvd[QUOT_W-1:0];
      assign d_in = geo_i.den;
      assign p_in = geo_i.pix;
    end else begin : g_next
      assign v_in = vld_q[i-1];
      assign r_in = rem_q[i-1];
      assign w_in = wrd_q[i-1];
      assign d_in = den_q[i-1];
      assign p_in = pix_q[i-1];
    end

    // partial remainder stays below den, so trial fits one extra bit
    assign trial = {r_in, w_in[QUOT_W-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i] <= 1'b0;
      else if (en_i) vld_q[i] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? SQ_W'(trial - {1'b0, d_in}) : trial[SQ_W-1:0];
        wrd_q[i] <= {w_in[QUOT_W-2:0], ge};
        den_q[i] <= d_in;
        pix_q[i] <= p_in;
      end
    end
  end

  assign valid_o = vld_q[QUOT_W-1];
  assign quot_o  = wrd_q[QUOT_W-1];
  assign pix_o   = pix_q[QUOT_W-1];

endmodule

// ===== rtl/core/aacs_sqrt.sv =====
module aacs_sqrt import aacs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [QUOT_W-1:0] val_i,
  input  pix_in_t           pix_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output pix_in_t           pix_o
);

  // Digit-by-digit integer root, one result bit per stage
  logic              vld_q [ROOT_W];
  logic [ROOT_W:0]   rem_q [ROOT_W];
  logic [ROOT_W-1:0] rt_q  [ROOT_W];
  logic [RAD_W-1:0]  rad_q [ROOT_W];
  pix_in_t           pix_q [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic              v_in;
    logic [ROOT_W:0]   r_in;
    logic [ROOT_W-1:0] q_in;
    logic [RAD_W-1:0]  a_in;
    pix_in_t           p_in;
    logic [ROOT_W+2:0] shifted, trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign q_in = '0;
      assign a_in = RAD_W'(val_i);
      assign p_in = pix_i;
    end else begin : g_next
      assign v_in = vld_q[i-1];
      assign r_in = rem_q[i-1];
      assign q_in = rt_q[i-1];
      assign a_in = rad_q[i-1];
      assign p_in = pix_q[i-1];
    end

    assign shifted = {r_in, a_in[RAD_W-1:RAD_W-2]};
    assign trial   = {1'b0, q_in, 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i] <= 1'b0;
      else if (en_i) vld_q[i] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? (ROOT_W+1)'(shifted - trial) : shifted[ROOT_W:0];
        rt_q[i]  <= {q_in[ROOT_W-2:0], ge};
        rad_q[i] <= {a_in[RAD_W-3:0], 2'b00};
        pix_q[i] <= p_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = rt_q[ROOT_W-1];
  assign pix_o   = pix_q[ROOT_W-1];

endmodule

// ===== rtl/core/aacs_shade.sv =====
module aacs_shade import aacs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] dist_i,
  input  pix_in_t           pix_i,
  input  cfg_t              cfg_i,
  output logic              valid_o,
  output pix_out_t          word_o
);

  // Coverage from distance, per shape
  logic signed [CV_W-1:0] dist_s, rad_s, half_s, diff, cov;
  logic                   known, hit;
  logic [COV_BITS-1:0]    cov_c;

  always_comb begin
    dist_s = $signed(CV_W'(dist_i));
    rad_s  = $signed(CV_W'({cfg_i.circle_radius, 8'd0}));
    half_s = $signed(CV_W'({cfg_i.stroke_width, 3'd0}));
    diff   = dist_s - rad_s;
    known  = 1'b1;
    case (cfg_i.shape_mode)
      SHAPE_DISC: cov = rad_s + HALF_PX - dist_s;
      SHAPE_RING: cov = ONE_PX - ((diff < 0) ? -diff : diff);
      SHAPE_SEG:  cov = half_s + HALF_PX - dist_s;
      default: begin
        cov   = '0;
        known = 1'b0;
      end
    endcase
    hit   = known && (cov > 0);
    cov_c = (cov > ONE_PX) ? COV_BITS'(256) : cov[COV_BITS-1:0];
  end

  logic                a_vld_q;
  logic [COV_BITS-1:0] a_cov_q;
  pix_in_t             a_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en_i) a_vld_q <= valid_i && hit;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_cov_q <= cov_c;
      a_pix_q <= pix_i;
    end
  end

  // Alpha modulation: floor(base_alpha * cov / 256)
  logic [ALPHA_BITS+COV_BITS-1:0] prod;
  logic                           b_vld_q;
  pix_out_t                       b_word_q;

  assign prod = cfg_i.base_alpha * a_cov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en_i) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_word_q.out_x     <= a_pix_q.pixel_x;
      b_word_q.out_y     <= a_pix_q.pixel_y;
      b_word_q.out_alpha <= prod[ALPHA_BITS+7:8];
    end
  end

  assign valid_o = b_vld_q;
  assign word_o  = b_word_q;

endmodule

// ===== rtl/core/aa_coverage_shader_core.sv =====
// Anti-aliased coverage shader for one disc, ring or stroked segment.
// Configuration: write cfg_we_i with a register index and data while the
// block is idle; the write takes effect at that clock edge.
// Input channel: one pixel coordinate per word on in_valid_i/in_ready_o.
// Output channel: the pixel with its modulated alpha on out_valid_o/
// out_ready_i; pixels with no coverage produce no word.
// A pixel passes through four geometry stages, one divider stage per
// quotient bit (2*COORD_BITS+17), one root stage per result bit
// (COORD_BITS+9), two shading stages and the output buffer.
// Throughput is one pixel per cycle while in_ready_o is high.
// All stages advance together; a two-word output buffer keeps taking
// results while the receiver stalls, and only when it is full and the
// receiver holds off does the pipeline, and in_ready_o, stop.
// Reset clears all valid bits and the buffer and loads the register
// defaults (disc, points at origin, radius 0, stroke 1 px, alpha 255).
module aa_coverage_shader_core import aacs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pix_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pix_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SHAPE_MODE:    cfg_q.shape_mode    <= cfg_data_i[1:0];
        REG_POINT_A_X:     cfg_q.point_a_x     <= cfg_data_i[COORD_BITS-1:0];
        REG_POINT_A_Y:     cfg_q.point_a_y     <= cfg_data_i[COORD_BITS-1:0];
        REG_POINT_B_X:     cfg_q.point_b_x     <= cfg_data_i[COORD_BITS-1:0];
        REG_POINT_B_Y:     cfg_q.point_b_y     <= cfg_data_i[COORD_BITS-1:0];
        REG_CIRCLE_RADIUS: cfg_q.circle_radius <= cfg_data_i[RADIUS_BITS-1:0];
        REG_STROKE_WIDTH:  cfg_q.stroke_width  <= cfg_data_i[STROKE_BITS-1:0];
        REG_BASE_ALPHA:    cfg_q.base_alpha    <= cfg_data_i[ALPHA_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable: buffer has room, or a word leaves this cycle
  logic [OBUF_CW-1:0] cnt_q;
  logic               en;

  assign en         = (cnt_q != OBUF_CW'(OBUF_DEPTH)) || out_ready_i;
  assign in_ready_o = en;

  logic              geo_vld, div_vld, sq_vld, sh_vld;
  geo_t              geo;
  logic [QUOT_W-1:0] quot;
  logic [ROOT_W-1:0] root;
  pix_in_t           div_pix, sq_pix;
  pix_out_t          sh_word;

  aacs_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pix_i   (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (geo_vld),
    .geo_o   (geo)
  );

  aacs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geo_vld),
    .geo_i   (geo),
    .valid_o (div_vld),
    .quot_o  (quot),
    .pix_o   (div_pix)
  );

  aacs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .val_i   (quot),
    .pix_i   (div_pix),
    .valid_o (sq_vld),
    .root_o  (root),
    .pix_o   (sq_pix)
  );

  aacs_shade u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .dist_i  (root),
    .pix_i   (sq_pix),
    .cfg_i   (cfg_q),
    .valid_o (sh_vld),
    .word_o  (sh_word)
  );

  // Two-word output buffer
  pix_out_t obuf_q [OBUF_DEPTH];
  logic     wr_ptr_q, rd_ptr_q;
  logic     push, pop;

  assign push = en && sh_vld;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + OBUF_CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - OBUF_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) obuf_q[wr_ptr_q] <= sh_word;
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = obuf_q[rd_ptr_q];

endmodule

// ===== rtl/core/aacs_checker.sv =====
module aacs_checker import aacs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input pix_in_t           in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pix_out_t          out_data_o,
  input logic              cfg_we_i,
  input logic [CFG_IW-1:0] cfg_idx_i,
  input logic [CFG_DW-1:0] cfg_data_i
);

  // A stalled output word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // A receiver that takes words never holds the input off
  a_ready_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled although output drains");

  // Empty output buffer means the pipeline is free to move
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output buffer");

endmodule

bind aa_coverage_shader_core aacs_checker u_aacs_checker (.*);

// ===== test/aacs_checker.sv =====
`timescale 1ns / 100ps

// Watches the configuration port and both pixel channels, works out the
// expected shaded word for every accepted pixel and compares the results.
module aacs_scoreboard import aacs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pix_in_t           in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pix_out_t          out_data_i,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  cfg_t     shade_cfg;
  pix_out_t shaded_q[$];

  initial fail_count_o = 0;

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // Largest q with q*q*den <= num * 65536, i.e. distance in 1/256 pixel
  function automatic longint q8_root(input bit [127:0] num, input bit [127:0] den);
    bit [127:0] q;
    bit [127:0] c;
    q = '0;
    for (int b = 31; b >= 0; b--) begin
      c = q | (128'd1 << b);
      if (c * c * den <= (num << 16)) q = c;
    end
    return longint'(q);
  endfunction

  function automatic bit [127:0] mag(input longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint radial(input longint x, input longint y);
    return q8_root(128'(x * x + y * y), 128'd1);
  endfunction

  // Coverage of one pixel against the current shape; 0 when nothing is written
  function automatic bit shade_pixel(input pix_in_t p, output pix_out_t r);
    longint px, py, ax, ay, bx, by, fx, fy, dx, dy, dot, len2, span, diff, cov;
    bit [127:0] cr;
    px = longint'($signed(p.pixel_x));
    py = longint'($signed(p.pixel_y));
    ax = longint'($signed(shade_cfg.point_a_x));
    ay = longint'($signed(shade_cfg.point_a_y));
    bx = longint'($signed(shade_cfg.point_b_x));
    by = longint'($signed(shade_cfg.point_b_y));
    fx = px - ax;
    fy = py - ay;
    case (shape_e'(shade_cfg.shape_mode))
      SHAPE_DISC: begin
        span = radial(fx, fy);
        cov  = longint'(shade_cfg.circle_radius) * 256 + 128 - span;
      end
      SHAPE_RING: begin
        span = radial(fx, fy);
        diff = span - longint'(shade_cfg.circle_radius) * 256;
        cov  = 256 - ((diff < 0) ? -diff : diff);
      end
      SHAPE_SEG: begin
        dx   = bx - ax;
        dy   = by - ay;
        dot  = fx * dx + fy * dy;
        len2 = dx * dx + dy * dy;
        if (len2 == 0 || dot <= 0) begin
          span = radial(fx, fy);
        end else if (dot >= len2) begin
          span = radial(px - bx, py - by);
        end else begin
          cr   = mag(fx * dy - fy * dx);
          span = q8_root(cr * cr, 128'(len2));
        end
        cov = longint'(shade_cfg.stroke_width) * 8 + 128 - span;
      end
      default: return 1'b0;
    endcase
    if (cov <= 0) return 1'b0;
    if (cov > 256) cov = 256;
    r.out_x     = p.pixel_x;
    r.out_y     = p.pixel_y;
    r.out_alpha = ALPHA_BITS'((longint'(shade_cfg.base_alpha) * cov) >> 8);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t want;
    if (!rst_ni) begin
      shade_cfg = CFG_RESET;
      shaded_q.delete();
    end else begin
      // register mirror
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SHAPE_MODE:    shade_cfg.shape_mode    = cfg_data_i[1:0];
          REG_POINT_A_X:     shade_cfg.point_a_x     = cfg_data_i[COORD_BITS-1:0];
          REG_POINT_A_Y:     shade_cfg.point_a_y     = cfg_data_i[COORD_BITS-1:0];
          REG_POINT_B_X:     shade_cfg.point_b_x     = cfg_data_i[COORD_BITS-1:0];
          REG_POINT_B_Y:     shade_cfg.point_b_y     = cfg_data_i[COORD_BITS-1:0];
          REG_CIRCLE_RADIUS: shade_cfg.circle_radius = cfg_data_i[RADIUS_BITS-1:0];
          REG_STROKE_WIDTH:  shade_cfg.stroke_width  = cfg_data_i[STROKE_BITS-1:0];
          REG_BASE_ALPHA:    shade_cfg.base_alpha    = cfg_data_i[ALPHA_BITS-1:0];
          default: ;
        endcase
      end
      // compare outgoing word with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (shaded_q.size() == 0) begin
          report($sformatf("unexpected word x=%0d y=%0d a=%0d", $signed(out_data_i.out_x),
                           $signed(out_data_i.out_y), out_data_i.out_alpha));
        end else begin
          want = shaded_q.pop_front();
          if (out_data_i.out_x !== want.out_x)
            report($sformatf("out_x %0d, want %0d", $signed(out_data_i.out_x),
                             $signed(want.out_x)));
          if (out_data_i.out_y !== want.out_y)
            report($sformatf("out_y %0d, want %0d", $signed(out_data_i.out_y),
                             $signed(want.out_y)));
          if (out_data_i.out_alpha !== want.out_alpha)
            report($sformatf("out_alpha %0d, want %0d at (%0d,%0d)", out_data_i.out_alpha,
                             want.out_alpha, $signed(want.out_x), $signed(want.out_y)));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (shade_pixel(in_data_i, want)) shaded_q.push_back(want);
      end
    end
    pending_o = shaded_q.size();
  end

  final begin
    if (shaded_q.size() != 0)
      $display("%0d expected words never arrived", shaded_q.size());
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import aacs_pkg::*;

  localparam int NUM_SETS     = 11;
  localparam int WORDS_PER_SET = 160;
  localparam int DRAIN_CYCLES = 100;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  pix_in_t           in_data_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  pix_out_t          out_data_o;
  logic              cfg_we_i   = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i  = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  int fail_count;
  int pending;
  int tx_idle_pct = 35;
  int rx_idle_pct = 73;
  bit hold_req    = 1'b0;

  cfg_t shape_set;

  aa_coverage_shader_core dut (.*);

  aacs_scoreboard checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, and a long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Narrow registers get random junk above their width
  function automatic logic [CFG_DW-1:0] with_junk(input int val, input int w);
    int mask;
    mask = (1 << w) - 1;
    return CFG_DW'(($urandom & ~mask) | (val & mask));
  endfunction

  task automatic load_shape(input cfg_t s);
    cfg_reg_e idx;
    logic [CFG_DW-1:0] d;
    idx = REG_SHAPE_MODE;
    for (int i = 0; i < 8; i++) begin
      case (idx)
        REG_SHAPE_MODE:    d = with_junk(s.shape_mode, 2);
        REG_POINT_A_X:     d = s.point_a_x;
        REG_POINT_A_Y:     d = s.point_a_y;
        REG_POINT_B_X:     d = s.point_b_x;
        REG_POINT_B_Y:     d = s.point_b_y;
        REG_CIRCLE_RADIUS: d = with_junk(s.circle_radius, RADIUS_BITS);
        REG_STROKE_WIDTH:  d = with_junk(s.stroke_width, STROKE_BITS);
        default:           d = with_junk(s.base_alpha, ALPHA_BITS);
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= d;
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one word, wait for the edge that takes it, then sometimes idle a while
  task automatic send_pixel(input int px, input int py);
    bit rdy;
    in_valid_i <= 1'b1;
    in_data_i  <= '{pixel_x: COORD_BITS'(px), pixel_y: COORD_BITS'(py)};
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic cfg_t pick_shape(input int n);
    cfg_t s;
    s = CFG_RESET;
    case (n)
      1: begin
        s.shape_mode = SHAPE_DISC; s.circle_radius = 5; s.base_alpha = 255;
      end
      2: begin
        s.shape_mode = SHAPE_RING; s.point_a_x = -2048; s.point_a_y = 2047;
        s.circle_radius = 1023; s.base_alpha = 128;
      end
      3: begin
        s.shape_mode = SHAPE_SEG; s.point_a_x = -2048; s.point_a_y = -2048;
        s.point_b_x = 2047; s.point_b_y = 2047; s.stroke_width = 1023;
      end
      4: begin
        // zero-length segment, zero stroke, zero alpha
        s.shape_mode = SHAPE_SEG; s.point_a_x = 100; s.point_a_y = -50;
        s.point_b_x = 100; s.point_b_y = -50; s.stroke_width = 0; s.base_alpha = 0;
      end
      5: begin
        s.shape_mode = 2'd3; s.circle_radius = 50;
      end
      default: begin
        s.shape_mode    = ($urandom_range(9) == 9) ? 2'd3 : 2'($urandom_range(2));
        s.point_a_x     = COORD_BITS'($urandom);
        s.point_a_y     = COORD_BITS'($urandom);
        s.point_b_x     = ($urandom_range(3) == 0) ? COORD_BITS'($urandom)
                          : s.point_a_x + COORD_BITS'($urandom_range(600) - 300);
        s.point_b_y     = s.point_a_y + COORD_BITS'($urandom_range(600) - 300);
        s.circle_radius = ($urandom_range(4) == 0) ? RADIUS_BITS'($urandom)
                          : RADIUS_BITS'($urandom_range(40));
        s.stroke_width  = STROKE_BITS'($urandom_range(1023));
        s.base_alpha    = ALPHA_BITS'($urandom);
      end
    endcase
    return s;
  endfunction

  // Random pixel, mostly near the shape edge or stroke
  task automatic send_near();
    int ax, ay, bx, by, k, spread, px, py;
    ax = $signed(shape_set.point_a_x);
    ay = $signed(shape_set.point_a_y);
    bx = $signed(shape_set.point_b_x);
    by = $signed(shape_set.point_b_y);
    if ($urandom_range(99) < 20) begin
      px = $urandom;
      py = $urandom;
    end else begin
      if (shape_set.shape_mode == SHAPE_SEG) begin
        k      = $urandom_range(10) - 1;
        px     = ax + (bx - ax) * k / 8;
        py     = ay + (by - ay) * k / 8;
        spread = shape_set.stroke_width / 16 + 3;
      end else begin
        px     = ax;
        py     = ay;
        spread = shape_set.circle_radius + 3;
      end
      px += $urandom_range(2 * spread) - spread;
      py += $urandom_range(2 * spread) - spread;
    end
    send_pixel(px, py);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int g = 0; g < NUM_SETS; g++) begin
      if (g == 4) begin
        tx_idle_pct = 73;
        rx_idle_pct = 35;
      end else if (g == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
      end
      shape_set = (g == 0) ? CFG_RESET : pick_shape(g);
      if (g != 0) load_shape(shape_set);

      // corners and both anchor points
      if (g < 4) begin
        send_pixel(-2048, -2048);
        send_pixel(2047, 2047);
        send_pixel(-2048, 2047);
        send_pixel(2047, -2048);
        send_pixel($signed(shape_set.point_a_x), $signed(shape_set.point_a_y));
        send_pixel($signed(shape_set.point_b_x), $signed(shape_set.point_b_y));
      end
      for (int i = 0; i < WORDS_PER_SET; i++) send_near();
      drain();
    end

    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
